>>> sv/ppta_pkg.sv
`timescale 1ns / 1ps
// Package for the planar PID thruster allocator: fixed-point constants,
// arctangent table, rounding and saturation helpers, multiplier op type.
// No dependencies.
package ppta_pkg;

    localparam int unsigned NUM_REGS     = 8;
    localparam int unsigned CORDIC_STEPS = 17;

    localparam logic signed [23:0] Q_PI      = 24'sd205887;
    localparam logic signed [23:0] Q_TWO_PI  = 24'sd411775;
    localparam logic signed [23:0] Q_HALF_PI = 24'sd102944;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [33:0] DT_Q32    = 34'sd21474836;

    // register indexes
    localparam logic [2:0] REG_KP_POS  = 3'd0;
    localparam logic [2:0] REG_KI_POS  = 3'd1;
    localparam logic [2:0] REG_KD_POS  = 3'd2;
    localparam logic [2:0] REG_KP_HDG  = 3'd3;
    localparam logic [2:0] REG_KI_HDG  = 3'd4;
    localparam logic [2:0] REG_KD_HDG  = 3'd5;
    localparam logic [2:0] REG_LIM_POS = 3'd6;
    localparam logic [2:0] REG_LIM_HDG = 3'd7;

    // one multiplier request: issue, restart the sum, subtract
    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
    } t_mac_op;

    function automatic logic signed [23:0] atan_lut(input logic [4:0] idx);
        logic signed [23:0] v;
        begin
            case (idx)
                5'd0:    v = 24'sd51472;
                5'd1:    v = 24'sd30386;
                5'd2:    v = 24'sd16055;
                5'd3:    v = 24'sd8150;
                5'd4:    v = 24'sd4091;
                5'd5:    v = 24'sd2047;
                5'd6:    v = 24'sd1024;
                5'd7:    v = 24'sd512;
                5'd8:    v = 24'sd256;
                5'd9:    v = 24'sd128;
                5'd10:   v = 24'sd64;
                5'd11:   v = 24'sd32;
                5'd12:   v = 24'sd16;
                5'd13:   v = 24'sd8;
                5'd14:   v = 24'sd4;
                5'd15:   v = 24'sd2;
                5'd16:   v = 24'sd1;
                default: v = 24'sd0;
            endcase
            return v;
        end
    endfunction

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [71:0] a);
        logic signed [31:0] r;
        begin
            if (a > 72'sh0_0000_0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (a < -72'sh0_0000_0000_8000_0000)
                r = 32'sh8000_0000;
            else
                r = a[31:0];
            return r;
        end
    endfunction

    // round half up at bit 16, floor shift, saturate
    function automatic logic signed [31:0] rnd16_sat(input logic signed [71:0] a);
        logic signed [71:0] t;
        begin
            t = (a + 72'sd32768) >>> 16;
            return sat32(t);
        end
    endfunction

endpackage

>>> sv/planar_pid_thruster_allocator.sv
`timescale 1ns / 1ps
// A control request passes through the heading wrap and the CORDIC loop, then
// through the sequencer on the one shared multiplier (20 products). One request
// at a time; a restart request clears the integrators and leaves the block
// idle. A finished result waits in an output register while the next request
// is accepted.
// Reset (synchronous, active low) clears gains, limits and integrators and
// marks the first step pending.
module planar_pid_thruster_allocator
    import ppta_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [30:0]  i_cfg_data,
    // request stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: pos_x, pos_y, heading[22], vel_x, vel_y, turn_rate,
    //        target_x, target_y, target_heading[22], 4 zero bits
    input  logic [271:0] i_s_axis_tdata,
    // tuser: action
    input  logic         i_s_axis_tuser,
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: thrust_front_left, thrust_front_right, thrust_back_left,
    //        thrust_back_right, thrust_left_front, thrust_left_back,
    //        thrust_right_front, thrust_right_back
    output logic [255:0] o_m_axis_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TRIG = 2'd1;
    localparam logic [1:0] ST_MAC  = 2'd2;
    localparam logic [4:0] LAST_STEP = 5'd23;

    logic [30:0]        r_reg [NUM_REGS];
    logic [1:0]         r_state;
    logic [4:0]         r_step;
    logic               r_first;
    logic               r_out_valid;
    logic [255:0]       r_out_data;
    logic signed [32:0] r_wx, r_wy;
    logic signed [32:0] r_vx, r_vy;
    logic signed [31:0] r_deth;
    logic signed [23:0] r_eth;
    logic signed [31:0] r_ex, r_ey, r_dex, r_dey, r_ux, r_uy;
    logic signed [31:0] r_ix, r_iy, r_ih;

    logic               w_in_acc;
    logic               w_cstart;
    logic               w_cdone;
    logic signed [17:0] w_cos, w_sin;
    t_mac_op            w_op;
    logic signed [33:0] w_a, w_b;
    logic signed [71:0] w_acc;
    logic signed [31:0] w_u;
    logic signed [33:0] w_int_in;
    logic [30:0]        w_lim;
    logic signed [33:0] w_int_new;
    logic signed [31:0] w_int_sat;
    logic               w_eth_ok;
    logic               w_emit;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cstart  = w_in_acc && !i_s_axis_tuser;
    assign w_eth_ok  = (r_eth <= Q_PI) && (r_eth >= -Q_PI);
    assign w_emit    = (r_state == ST_MAC) && (r_step == LAST_STEP)
                       && (!r_out_valid || i_m_axis_tready);

    ppta_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (i_s_axis_tdata[85:64]),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // operand selection for each sequencer step
    always_comb begin
        w_op = '{en: 1'b0, clr: 1'b0, neg: 1'b0};
        w_a  = '0;
        w_b  = '0;
        if (r_state == ST_MAC) begin
            case (r_step)
                5'd0:  begin w_op = '{1'b1, 1'b1, 1'b0}; w_a = 34'(w_cos); w_b = 34'(r_wx); end
                5'd1:  begin w_op = '{1'b1, 1'b0, 1'b0}; w_a = 34'(w_sin); w_b = 34'(r_wy); end
                5'd2:  begin w_op = '{1'b1, 1'b1, 1'b0}; w_a = 34'(w_cos); w_b = 34'(r_wy); end
                5'd3:  begin w_op = '{1'b1, 1'b0, 1'b1}; w_a = 34'(w_sin); w_b = 34'(r_wx); end
                5'd4:  begin w_op = '{1'b1, 1'b1, 1'b1}; w_a = 34'(w_cos); w_b = 34'(r_vx); end
                5'd5:  begin w_op = '{1'b1, 1'b0, 1'b1}; w_a = 34'(w_sin); w_b = 34'(r_vy); end
                5'd6:  begin w_op = '{1'b1, 1'b1, 1'b0}; w_a = 34'(w_sin); w_b = 34'(r_vx); end
                5'd7:  begin w_op = '{1'b1, 1'b0, 1'b1}; w_a = 34'(w_cos); w_b = 34'(r_vy); end
                5'd8:  begin w_op = '{1'b1, 1'b1, 1'b0}; w_a = 34'(r_ex);  w_b = DT_Q32; end
                5'd9:  begin w_op = '{1'b1, 1'b1, 1'b0}; w_a = 34'(r_ey);  w_b = DT_Q32; end
                5'd10: begin w_op = '{1'b1, 1'b1, 1'b0}; w_a = 34'(r_eth); w_b = DT_Q32; end
                5'd13: begin
                    w_op = '{1'b1, 1'b1, 1'b0};
                    w_a = {3'b0, r_reg[REG_KP_POS]}; w_b = 34'(r_ex);
                end
                5'd14: begin
                    w_op = '{1'b1, 1'b0, 1'b0};
                    w_a = {3'b0, r_reg[REG_KI_POS]}; w_b = 34'(r_ix);
                end
                5'd15: begin
                    w_op = '{1'b1, 1'b0, 1'b0};
                    w_a = {3'b0, r_reg[REG_KD_POS]}; w_b = 34'(r_dex);
                end
                5'd16: begin
                    w_op = '{1'b1, 1'b1, 1'b0};
                    w_a = {3'b0, r_reg[REG_KP_POS]}; w_b = 34'(r_ey);
                end
                5'd17: begin
                    w_op = '{1'b1, 1'b0, 1'b0};
                    w_a = {3'b0, r_reg[REG_KI_POS]}; w_b = 34'(r_iy);
                end
                5'd18: begin
                    w_op = '{1'b1, 1'b0, 1'b0};
                    w_a = {3'b0, r_reg[REG_KD_POS]}; w_b = 34'(r_dey);
                end
                5'd19: begin
                    w_op = '{1'b1, 1'b1, 1'b0};
                    w_a = {3'b0, r_reg[REG_KP_HDG]}; w_b = 34'(r_eth);
                end
                5'd20: begin
                    w_op = '{1'b1, 1'b0, 1'b0};
                    w_a = {3'b0, r_reg[REG_KI_HDG]}; w_b = 34'(r_ih);
                end
                5'd21: begin
                    w_op = '{1'b1, 1'b0, 1'b0};
                    w_a = {3'b0, r_reg[REG_KD_HDG]}; w_b = 34'(r_deth);
                end
                default: ;
            endcase
        end
    end

    ppta_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc)
    );

    assign w_u = rnd16_sat(w_acc);

    // integrator step: round the 0.005 product, add, clamp
    always_comb begin
        w_int_in = 34'(r_ix);
        w_lim    = r_reg[REG_LIM_POS];
        case (r_step)
            5'd11:   w_int_in = 34'(r_iy);
            5'd12: begin
                w_int_in = 34'(r_ih);
                w_lim    = r_reg[REG_LIM_HDG];
            end
            default: ;
        endcase
        w_int_new = w_int_in + 34'((w_acc + 72'sh8000_0000) >>> 32);
        if (w_int_new > $signed({3'b0, w_lim}))
            w_int_sat = $signed({1'b0, w_lim});
        else if (w_int_new < -$signed({3'b0, w_lim}))
            w_int_sat = -$signed({1'b0, w_lim});
        else
            w_int_sat = w_int_new[31:0];
    end

    // thruster split of the three commands
    function automatic logic [255:0] split(input logic signed [31:0] ux,
                                           input logic signed [31:0] uy,
                                           input logic signed [31:0] ut);
        logic signed [33:0] fw, bk, t, l;
        begin
            fw = (ux > 0) ? 34'(ux) : 34'sd0;
            bk = (ux < 0) ? -34'(ux) : 34'sd0;
            t  = 34'(ut);
            l  = 34'(uy);
            return {sat32(72'(-l)), sat32(72'(-l)), sat32(72'(l)), sat32(72'(l)),
                    sat32(72'(bk - t)), sat32(72'(bk + t)),
                    sat32(72'(fw + t)), sat32(72'(fw - t))};
        end
    endfunction

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_reg[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_reg[i_cfg_addr] <= i_cfg_data;
        end
    end

    // sequencer and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_ix        <= '0;
            r_iy        <= '0;
            r_ih        <= '0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tuser) begin
                            r_ix    <= '0;
                            r_iy    <= '0;
                            r_ih    <= '0;
                            r_first <= 1'b1;
                        end else begin
                            r_eth   <= 24'($signed(i_s_axis_tdata[267:246]))
                                       - 24'($signed(i_s_axis_tdata[85:64]));
                            r_state <= ST_TRIG;
                        end
                    end
                end
                ST_TRIG: begin
                    if (r_eth > Q_PI) begin
                        r_eth <= r_eth - Q_TWO_PI;
                    end else if (r_eth < -Q_PI) begin
                        r_eth <= r_eth + Q_TWO_PI;
                    end
                    if (w_cdone && w_eth_ok) begin
                        r_step  <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (r_step != LAST_STEP) begin
                        r_step <= r_step + 5'd1;
                    end
                    case (r_step)
                        5'd10: if (!r_first) r_ix <= w_int_sat;
                        5'd11: if (!r_first) r_iy <= w_int_sat;
                        5'd12: begin
                            if (!r_first) r_ih <= w_int_sat;
                            r_first <= 1'b0;
                        end
                        default: ;
                    endcase
                    if (w_emit) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_cstart) begin
            r_wx   <= 33'($signed(i_s_axis_tdata[213:182])) - 33'($signed(i_s_axis_tdata[31:0]));
            r_wy   <= 33'($signed(i_s_axis_tdata[245:214])) - 33'($signed(i_s_axis_tdata[63:32]));
            r_vx   <= 33'($signed(i_s_axis_tdata[117:86]));
            r_vy   <= 33'($signed(i_s_axis_tdata[149:118]));
            r_deth <= sat32(-72'($signed(i_s_axis_tdata[181:150])));
        end
        if (r_state == ST_MAC) begin
            case (r_step)
                5'd3:  r_ex  <= w_u;
                5'd5:  r_ey  <= w_u;
                5'd7:  r_dex <= w_u;
                5'd9:  r_dey <= w_u;
                5'd17: r_ux  <= w_u;
                5'd20: r_uy  <= w_u;
                default: ;
            endcase
        end
        if (w_emit) begin
            r_out_data <= split(r_ux, r_uy, w_u);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> sv/ppta_cordic.sv
`timescale 1ns / 1ps
// Iterative angle wrap and 17-step rotation-mode CORDIC giving cosine and
// sine of a Q6.16 heading. Depends on ppta_pkg.
module ppta_cordic
    import ppta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [21:0] i_angle,
    output logic               o_done,
    output logic signed [17:0] o_cos,
    output logic signed [17:0] o_sin
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_WRAP = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_done, n_done;
    logic               r_neg, n_neg;
    logic [4:0]         r_idx, n_idx;
    logic signed [23:0] r_z, n_z;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [33:0] w_xr;
    logic signed [33:0] w_yr;

    // next state: wrap, fold into the right half plane, rotate
    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        n_neg   = r_neg;
        n_idx   = r_idx;
        n_z     = r_z;
        n_x     = r_x;
        n_y     = r_y;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_z     = {{2{i_angle[21]}}, i_angle};
                    n_done  = 1'b0;
                    n_state = C_WRAP;
                end
            end
            C_WRAP: begin
                if (r_z > Q_PI) begin
                    n_z = r_z - Q_TWO_PI;
                end else if (r_z < -Q_PI) begin
                    n_z = r_z + Q_TWO_PI;
                end else begin
                    n_neg = 1'b0;
                    if (r_z > Q_HALF_PI) begin
                        n_z   = r_z - Q_PI;
                        n_neg = 1'b1;
                    end else if (r_z < -Q_HALF_PI) begin
                        n_z   = r_z + Q_PI;
                        n_neg = 1'b1;
                    end
                    n_x     = CORDIC_X0;
                    n_y     = '0;
                    n_idx   = '0;
                    n_state = C_ITER;
                end
            end
            C_ITER: begin
                if (r_z >= 0) begin
                    n_x = r_x - (r_y >>> r_idx);
                    n_y = r_y + (r_x >>> r_idx);
                    n_z = r_z - atan_lut(r_idx);
                end else begin
                    n_x = r_x + (r_y >>> r_idx);
                    n_y = r_y - (r_x >>> r_idx);
                    n_z = r_z + atan_lut(r_idx);
                end
                n_idx = r_idx + 5'd1;
                if (r_idx == 5'(CORDIC_STEPS - 1)) begin
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_neg <= n_neg;
        r_idx <= n_idx;
        r_z   <= n_z;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    // round Q2.30 to Q2.16 and undo the fold
    assign w_xr = (r_x + 34'sd8192) >>> 14;
    assign w_yr = (r_y + 34'sd8192) >>> 14;
    assign o_cos  = r_neg ? -w_xr[17:0] : w_xr[17:0];
    assign o_sin  = r_neg ? -w_yr[17:0] : w_yr[17:0];
    assign o_done = r_done;

endmodule

>>> sv/ppta_mac.sv
`timescale 1ns / 1ps
// Shared signed multiply-accumulate unit: registered product, then a wide
// accumulator that restarts, adds or subtracts. Depends on ppta_pkg.
module ppta_mac
    import ppta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_op            i_op,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [71:0] o_acc
);

    t_mac_op            r_pop;
    logic signed [67:0] r_prod;
    logic signed [71:0] r_acc;
    logic signed [71:0] w_term;

    // stage one: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop <= '0;
        end else begin
            r_pop <= i_op;
        end
        r_prod <= i_a * i_b;
    end

    assign w_term = r_pop.neg ? -{{4{r_prod[67]}}, r_prod} : {{4{r_prod[67]}}, r_prod};

    // stage two: accumulate
    always_ff @(posedge i_clk) begin
        if (r_pop.en) begin
            r_acc <= r_pop.clr ? w_term : r_acc + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> sv/ppta_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the planar PID thruster allocator, bound to the top
// level. Depends on planar_pid_thruster_allocator.
module ppta_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [255:0] o_m_axis_tdata
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a control request occupies the block
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser |=> !o_s_axis_tready)
        else $error("control request did not occupy the block");

    // a restart request gives no result and frees the block at once
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser
        |=> o_s_axis_tready && (o_m_axis_tvalid == $past(o_m_axis_tvalid && !i_m_axis_tready)))
        else $error("restart request misbehaved");

    // lateral thrusters on each side agree
    a_lateral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[159:128] == o_m_axis_tdata[191:160]
                         && o_m_axis_tdata[223:192] == o_m_axis_tdata[255:224])
        else $error("lateral thrusters disagree");

endmodule

bind planar_pid_thruster_allocator ppta_checker u_ppta_checker (.*);

>>> tb/tb_planar_pid_thruster_allocator.sv
`timescale 1ns / 1ps
// Self-checking bench for the planar PID thruster allocator: a directed table and
// random control and restart requests, predicted by an in-bench PID/CORDIC model.
// Depends on ppta_pkg and planar_pid_thruster_allocator.
module tb_planar_pid_thruster_allocator;
    import ppta_pkg::*;

    typedef struct {
        bit                 restart;
        logic signed [31:0] pos_x, pos_y;
        logic signed [21:0] heading;
        logic signed [31:0] vel_x, vel_y, turn_rate, target_x, target_y;
        logic signed [21:0] target_heading;
    } t_pose_req;

    typedef struct {
        t_pose_req    req;
        bit           known;
        logic [255:0] thrust;
    } t_table_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [30:0]  i_cfg_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // tdata: pos_x, pos_y, heading[22], vel_x, vel_y, turn_rate,
    //        target_x, target_y, target_heading[22], 4 zero bits
    logic [271:0] i_s_axis_tdata;
    // tuser: action
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // tdata: thrust_front_left, thrust_front_right, thrust_back_left,
    //        thrust_back_right, thrust_left_front, thrust_left_back,
    //        thrust_right_front, thrust_right_back
    logic [255:0] o_m_axis_tdata;

    planar_pid_thruster_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    localparam longint CYCLE_LIMIT = 3000000;

    logic [30:0]  gain_reg [NUM_REGS];
    longint       acc_x, acc_y, acc_hdg;
    bit           first_pending;
    logic [255:0] thrust_queue [$];
    int           n_errors;
    longint       n_cycles;
    bit           calm;
    t_table_row   dir_rows [$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 11);
    endfunction

    // ---------------- predictor ----------------
    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint wrap_angle(longint a);
        while (a > longint'(Q_PI)) a -= longint'(Q_TWO_PI);
        while (a < -longint'(Q_PI)) a += longint'(Q_TWO_PI);
        return a;
    endfunction

    task automatic heading_trig(input longint h, output longint c, output longint s);
        longint z, x, y, nx, at;
        bit     flip;
        z = wrap_angle(h);
        x = longint'(CORDIC_X0);
        y = 0;
        flip = 0;
        if (z > longint'(Q_HALF_PI)) begin
            z -= longint'(Q_PI);
            flip = 1;
        end else if (z < -longint'(Q_HALF_PI)) begin
            z += longint'(Q_PI);
            flip = 1;
        end
        // rotate toward zero residual angle
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            at = longint'(atan_lut(i[4:0]));
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= at;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += at;
            end
            x = nx;
        end
        c = rnd_shift(x, 14);
        s = rnd_shift(y, 14);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endtask

    function automatic longint pid_sum(logic [30:0] g1, longint v1, logic [30:0] g2,
                                       longint v2, logic [30:0] g3, longint v3);
        longint p [3];
        longint hi, lo;
        p[0] = longint'(g1) * v1;
        p[1] = longint'(g2) * v2;
        p[2] = longint'(g3) * v3;
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++) begin
            hi += p[k] >>> 16;
            lo += p[k] & 64'hFFFF;
        end
        return clip32(hi + ((lo + 64'sh8000) >>> 16));
    endfunction

    function automatic longint step_integrator(longint acc, longint e, logic [30:0] lim);
        longint v;
        v = acc + rnd_shift(e * longint'(DT_Q32), 32);
        if (v > longint'(lim)) v = longint'(lim);
        if (v < -longint'(lim)) v = -longint'(lim);
        return v;
    endfunction

    task automatic predict_thrust(input t_pose_req r, output bit emits,
                                  output logic [255:0] thrust);
        longint c, s, wx, wy, ex, ey, eth, dex, dey, deth, ux, uy, uth, fw, bk;
        longint hd, vx, vy;
        longint mix [8];
        thrust = '0;
        emits = 0;
        if (r.restart) begin
            acc_x = 0;
            acc_y = 0;
            acc_hdg = 0;
            first_pending = 1;
            return;
        end
        hd = longint'(r.heading);
        vx = longint'(r.vel_x);
        vy = longint'(r.vel_y);
        heading_trig(hd, c, s);
        wx = longint'(r.target_x) - longint'(r.pos_x);
        wy = longint'(r.target_y) - longint'(r.pos_y);
        ex = clip32(rnd_shift(c * wx + s * wy, 16));
        ey = clip32(rnd_shift(c * wy - s * wx, 16));
        eth = wrap_angle(longint'(r.target_heading) - hd);
        // integrators hold on the first step after reset or restart
        if (!first_pending) begin
            acc_x = step_integrator(acc_x, ex, gain_reg[REG_LIM_POS]);
            acc_y = step_integrator(acc_y, ey, gain_reg[REG_LIM_POS]);
            acc_hdg = step_integrator(acc_hdg, eth, gain_reg[REG_LIM_HDG]);
        end
        first_pending = 0;
        dex = clip32(rnd_shift(-(c * vx + s * vy), 16));
        dey = clip32(rnd_shift(s * vx - c * vy, 16));
        deth = clip32(-longint'(r.turn_rate));
        ux = pid_sum(gain_reg[REG_KP_POS], ex, gain_reg[REG_KI_POS], acc_x,
                     gain_reg[REG_KD_POS], dex);
        uy = pid_sum(gain_reg[REG_KP_POS], ey, gain_reg[REG_KI_POS], acc_y,
                     gain_reg[REG_KD_POS], dey);
        uth = pid_sum(gain_reg[REG_KP_HDG], eth, gain_reg[REG_KI_HDG], acc_hdg,
                      gain_reg[REG_KD_HDG], deth);
        fw = (ux > 0) ? ux : 0;
        bk = (ux < 0) ? -ux : 0;
        mix[0] = fw - uth;
        mix[1] = fw + uth;
        mix[2] = bk + uth;
        mix[3] = bk - uth;
        mix[4] = uy;
        mix[5] = uy;
        mix[6] = -uy;
        mix[7] = -uy;
        for (int k = 0; k < 8; k++) thrust[32*k +: 32] = 32'(clip32(mix[k]));
        emits = 1;
    endtask

    // ---------------- stimulus ----------------
    function automatic logic [271:0] pack_pose(t_pose_req r);
        return {4'b0, r.target_heading, r.target_y, r.target_x, r.turn_rate,
                r.vel_y, r.vel_x, r.heading, r.pos_y, r.pos_x};
    endfunction

    function automatic t_pose_req make_req(bit rs, int px, int py, int hd, int vx,
                                           int vy, int om, int tx, int ty, int th);
        t_pose_req r;
        r.restart = rs;
        r.pos_x = px;
        r.pos_y = py;
        r.heading = 22'(hd);
        r.vel_x = vx;
        r.vel_y = vy;
        r.turn_rate = om;
        r.target_x = tx;
        r.target_y = ty;
        r.target_heading = 22'(th);
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 99) < 20) return $urandom;
        return $urandom_range(0, 400 << 16) - (200 << 16);
    endfunction

    function automatic logic [21:0] rand_angle();
        if ($urandom_range(0, 99) < 10) return 22'($urandom);
        return 22'($urandom_range(0, 2 * 1647099) - 1647099);
    endfunction

    function automatic t_pose_req rand_req();
        t_pose_req r;
        r.restart = ($urandom_range(0, 99) < 5);
        r.pos_x = rand_word();
        r.pos_y = rand_word();
        r.heading = rand_angle();
        r.vel_x = rand_word();
        r.vel_y = rand_word();
        r.turn_rate = rand_word();
        r.target_x = rand_word();
        r.target_y = rand_word();
        r.target_heading = rand_angle();
        return r;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        gain_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input logic [30:0] kpp, kip, kdp, kph, kih, kdh, lp, lh);
        cfg_write(REG_KP_POS, kpp);
        cfg_write(REG_KI_POS, kip);
        cfg_write(REG_KD_POS, kdp);
        cfg_write(REG_KP_HDG, kph);
        cfg_write(REG_KI_HDG, kih);
        cfg_write(REG_KD_HDG, kdh);
        cfg_write(REG_LIM_POS, lp);
        cfg_write(REG_LIM_HDG, lh);
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (thrust_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // drive one request; we enter and leave at a falling edge
    task automatic send_req(input t_pose_req r, input bit known, input logic [255:0] typed);
        bit           emits;
        logic [255:0] thrust;
        while (idle_now()) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= pack_pose(r);
        i_s_axis_tuser <= r.restart;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        predict_thrust(r, emits, thrust);
        if (emits) thrust_queue.push_back(known ? typed : thrust);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ---------------- receiver side ----------------
    always @(negedge i_clk) begin
        if (i_rst_n) i_m_axis_tready <= !idle_now();
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        logic [255:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (thrust_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_axis_tdata);
                n_errors++;
            end else begin
                want = thrust_queue.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (want[32*k +: 32] !== o_m_axis_tdata[32*k +: 32]) begin
                        $display("%0t: thruster %0d expected %h actual %h", $time, k,
                                 want[32*k +: 32], o_m_axis_tdata[32*k +: 32]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        logic [30:0] g [8];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_m_axis_tready = 1'b0;
        n_errors = 0;
        n_cycles = 0;
        calm = 0;
        for (int k = 0; k < NUM_REGS; k++) gain_reg[k] = '0;
        acc_x = 0;
        acc_y = 0;
        acc_hdg = 0;
        first_pending = 1;

        // with all gains zero after reset every thruster reads zero
        dir_rows.push_back('{make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        dir_rows.push_back('{make_req(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1647099, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1647099), 1, '0});
        dir_rows.push_back('{make_req(0, 32'h80000000, 32'h80000000, -1647099, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, -1647099), 1, '0});
        dir_rows.push_back('{make_req(0, 32'h80000000, 32'h7FFFFFFF, 2097151, 32'h80000000,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, -2097152), 1, '0});
        dir_rows.push_back('{make_req(1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1, '0});
        foreach (dir_rows[i]) begin
            if (i == 0) begin
                repeat (6) @(posedge i_clk);
                @(negedge i_clk);
                i_rst_n = 1'b1;
            end
            send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].thrust);
        end
        stop_sending();
        drain();

        // moderate gains: first step, quadrant edges, wrap, saturation
        set_gains(31'h0002_0000, 31'h0000_8000, 31'h0000_4000, 31'h0003_0000,
                  31'h0001_0000, 31'h0000_2000, 31'h0010_0000, 31'h0004_0000);
        dir_rows.delete();
        dir_rows.push_back('{make_req(0, 0, 0, 0, 0, 0, 0, 10 << 16, 5 << 16, 0), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, 102944, 1 << 16, 0, 0, 10 << 16, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, 102945, 0, 1 << 16, 0, 0, 3 << 16, 0), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, -102945, 0, 0, 1 << 16, 4 << 16, 0,
            205887), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, 205887, 0, 0, 0, 0, 0, -205887), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, 205888, 0, 0, 0, 0, 0, -205888), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, -205888, 0, 0, 0, 1 << 16, 1 << 16,
            1647099), 0, '0});
        dir_rows.push_back('{make_req(0, 32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF,
            32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0), 0, '0});
        dir_rows.push_back('{make_req(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, 51472, 0, 0, 0, 20 << 16, -7 << 16,
            -51472), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, 51472, 0, 0, 0, 20 << 16, -7 << 16,
            -51472), 0, '0});
        dir_rows.push_back('{make_req(0, 0, 0, -2097152, 0, 0, 0, 0, 0, 2097151), 0, '0});
        foreach (dir_rows[i]) send_req(dir_rows[i].req, 0, '0);
        stop_sending();
        drain();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 8; k++) begin
                case (ph)
                    0: g[k] = 31'($urandom_range(0, 4 << 16));
                    1: g[k] = 31'h7FFF_FFFF;
                    2: g[k] = 31'($urandom_range(0, 1 << 12));
                    3: g[k] = (k >= 6) ? 31'd0 : 31'($urandom_range(0, 8 << 16));
                    4: g[k] = 31'($urandom);
                    default: g[k] = 31'($urandom_range(0, 2 << 16));
                endcase
            end
            if (ph == 4) g[6] = 31'h7FFF_FFFF;
            set_gains(g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]);
            for (int n = 0; n < 280; n++) begin
                calm = (ph == 2 && n >= 60 && n < 200);
                if (ph == 5 && n == 140) begin
                    // hold off until every result is back
                    i_s_axis_tvalid <= 1'b0;
                    while (thrust_queue.size() != 0) @(negedge i_clk);
                end
                send_req(rand_req(), 0, '0);
            end
            calm = 0;
            stop_sending();
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && thrust_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
